>>> rtl/pce_pkg.sv
// ----------------------------------------------------------------------------
// pce_pkg
// Shared widths, register indexes and defaults for the polar code encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pce_pkg;

  // widths of the stream words and of the configuration port
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned LOG2_W     = 3;

  // default upper bound on the code length
  localparam int unsigned MAX_CODE_LENGTH = 64;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_FROZEN_MASK = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CODE_LOG2   = 1'b1;

  // reset values of the configuration registers
  localparam logic [DATA_W-1:0] FROZEN_MASK_RST = '0;
  localparam logic [LOG2_W-1:0] CODE_LOG2_RST   = 3'd6;

  // number of register stages from input transfer to output register
  localparam int unsigned PIPE_DEPTH = 5;

endpackage

`default_nettype wire

>>> rtl/polar_code_encoder.sv
// ----------------------------------------------------------------------------
// polar_code_encoder
// Places the information bits at the unfrozen positions and runs the polar
// butterfly transform over the frame; one frame per cycle if not stalled.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              contents
//  s_axis    in         tvalid/tready          tdata[63:0] = info_word
//  m_axis    out        tvalid/tready          tdata[63:0] = codeword
//  cfg       in         cfg_we_i (no wait)     cfg_addr_i selects, cfg_wdata_i
//
//  five register stages: latch and length mask, group prefix counts,
//  position ranks, bit placement, butterfly into the output register
//  one frame per cycle sustained while the output does not stall
//  each stage holds its own valid bit, so bubbles fill in while the output
//  waits and a stall drops or repeats nothing
//  reset clears valid bits, frozen mask to zero and code length log2 to six
// ----------------------------------------------------------------------------
`default_nettype none

module polar_code_encoder
  import pce_pkg::*;
#(
  parameter int unsigned MaxCodeLength = pce_pkg::MAX_CODE_LENGTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [DATA_W-1:0]     cfg_wdata_i,
  // input frames
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [DATA_W-1:0]     s_axis_tdata,   // [63:0] info_word
  // output codewords
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [DATA_W-1:0]          m_axis_tdata    // [63:0] codeword
);

  // largest log2 length allowed and the internal frame width
  localparam int unsigned LogLim = $clog2(MaxCodeLength + 1) - 1;
  localparam int unsigned CwW    = 1 << LogLim;
  localparam int unsigned GrpSz  = (CwW < 8) ? CwW : 8;
  localparam int unsigned NumGrp = CwW / GrpSz;
  localparam int unsigned LocW   = $clog2(GrpSz);
  localparam int unsigned GcW    = $clog2(GrpSz + 1);
  localparam int unsigned OffW   = LogLim + 1;

  // configuration registers
  logic [DATA_W-1:0] frozen_q;
  logic [LOG2_W-1:0] log2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frozen_q <= FROZEN_MASK_RST;
      log2_q   <= CODE_LOG2_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FROZEN_MASK: frozen_q <= cfg_wdata_i;
        CFG_CODE_LOG2:   log2_q   <= cfg_wdata_i[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake: a stage takes new data when empty or when it moves on
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic r1, r2, r3, r4, r5;

  assign r5 = !v5_q || m_axis_tready;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign s_axis_tready = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (r1) v1_q <= s_axis_tvalid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
    end
  end

  // ---------------- stage 1: latch info and unfrozen positions below n
  logic [LOG2_W-1:0] m_eff;
  logic [CwW-1:0]    unf_d;
  logic [CwW-1:0]    unf1_q;
  logic [CwW-1:0]    info1_q;

  always_comb begin
    if (log2_q == '0) begin
      m_eff = LOG2_W'(1);
    end else if (log2_q > LOG2_W'(LogLim)) begin
      m_eff = LOG2_W'(LogLim);
    end else begin
      m_eff = log2_q;
    end
    for (int p = 0; p < CwW; p++) begin
      unf_d[p] = !frozen_q[p] && ((LogLim'(p) >> m_eff) == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && s_axis_tvalid) begin
      unf1_q  <= unf_d;
      info1_q <= s_axis_tdata[CwW-1:0];
    end
  end

  // ---------------- stage 2: prefix counts inside each group of positions
  logic [LocW-1:0] loc_d  [CwW];
  logic [GcW-1:0]  gcnt_d [NumGrp];
  logic [LocW-1:0] loc2_q [CwW];
  logic [GcW-1:0]  gcnt2_q[NumGrp];
  logic [CwW-1:0]  unf2_q;
  logic [CwW-1:0]  info2_q;

  always_comb begin
    logic [GcW-1:0] acc;
    for (int g = 0; g < NumGrp; g++) begin
      acc = '0;
      for (int i = 0; i < GrpSz; i++) begin
        loc_d[g*GrpSz + i] = LocW'(acc);
        acc = acc + GcW'(unf1_q[g*GrpSz + i]);
      end
      gcnt_d[g] = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      loc2_q  <= loc_d;
      gcnt2_q <= gcnt_d;
      unf2_q  <= unf1_q;
      info2_q <= info1_q;
    end
  end

  // ---------------- stage 3: rank of each position among unfrozen ones
  logic [LogLim-1:0] rank_d [CwW];
  logic [LogLim-1:0] rank3_q[CwW];
  logic [CwW-1:0]    unf3_q;
  logic [CwW-1:0]    info3_q;

  always_comb begin
    logic [OffW-1:0] off;
    off = '0;
    for (int g = 0; g < NumGrp; g++) begin
      for (int i = 0; i < GrpSz; i++) begin
        rank_d[g*GrpSz + i] = LogLim'(off + OffW'(loc2_q[g*GrpSz + i]));
      end
      off = off + OffW'(gcnt2_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      rank3_q <= rank_d;
      unf3_q  <= unf2_q;
      info3_q <= info2_q;
    end
  end

  // ---------------- stage 4: scatter info bits onto unfrozen positions
  logic [CwW-1:0] word_d;
  logic [CwW-1:0] word4_q;

  always_comb begin
    for (int p = 0; p < CwW; p++) begin
      word_d[p] = unf3_q[p] && info3_q[rank3_q[p]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (r4 && v3_q) begin
      word4_q <= word_d;
    end
  end

  // ---------------- stage 5: butterfly transform into the output register
  // positions at or above n are zero, so running every level is harmless
  logic [CwW-1:0] cw_d;
  logic [CwW-1:0] cw5_q;

  always_comb begin
    cw_d = word4_q;
    for (int s = 0; s < LogLim; s++) begin
      for (int p = 0; p < CwW; p++) begin
        if (((p >> s) & 1) == 0) begin
          cw_d[p] = cw_d[p] ^ cw_d[p + (1 << s)];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r5 && v4_q) begin
      cw5_q <= cw_d;
    end
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = DATA_W'(cw5_q);

endmodule

`default_nettype wire

>>> rtl/pce_checker.sv
// ----------------------------------------------------------------------------
// pce_checker
// Port-level checks on the polar code encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pce_checker
  import pce_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned PendW = $clog2(PIPE_DEPTH + 2);

  logic             in_xfer;
  logic             out_xfer;
  logic [PendW-1:0] pend_q;
  logic [PendW-1:0] pend_d;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // frames in flight between input and output transfer
  always_comb begin
    pend_d = pend_q;
    if (in_xfer && !out_xfer) begin
      pend_d = pend_q + PendW'(1);
    end else if (out_xfer && !in_xfer) begin
      pend_d = pend_q - PendW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // a stalled codeword holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("codeword changed while stalled");

  // no codeword without a frame taken in
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != '0)
    else $error("codeword without input frame");

  // pipeline never holds more frames than it has stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendW'(PIPE_DEPTH))
    else $error("more frames in flight than stages");

  // with the output register empty every stage can take data
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind polar_code_encoder pce_checker u_pce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
